@@ hw/rtl/text_console_writer_macros.svh @@
// assertion macros shared by the console checker
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// plain property, checked on every clock edge out of reset
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
  `TCW_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  `TCW_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/tcw_pkg.sv @@
// types, constants and helper functions of the text console writer
package tcw_pkg;

  // screen geometry
  localparam int unsigned COLS      = 80;
  localparam int unsigned ROWS      = 25;
  localparam int unsigned TAB_WIDTH = 4;
  localparam int unsigned CELLS     = COLS * ROWS;

  localparam int unsigned COL_W  = $clog2(COLS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned ADDR_W = $clog2(CELLS);

  // fixed field widths of the words
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned POS_COL_W  = 7;
  localparam int unsigned POS_ROW_W  = 5;
  localparam int unsigned OFFSET_W   = 11;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned CELL_W     = CHAR_W + 2 * COLOR_W;
  localparam int unsigned REG_IDX_W  = 1;
  localparam int unsigned OFF_CALC_W = (ADDR_W > OFFSET_W) ? ADDR_W : OFFSET_W;

  // limits and reset values
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
  localparam logic [ROW_W-1:0]  ROW_RESET = ROW_W'((ROWS > 5) ? 5 : ROWS - 1);

  // character codes
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // colors
  localparam logic [COLOR_W-1:0] COLOR_GREY  = 4'd7;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 4'd0;
  localparam logic [COLOR_W-1:0] FG_RESET    = COLOR_GREY;
  localparam logic [COLOR_W-1:0] BG_RESET    = COLOR_BLACK;

  // command queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT        = 2'd0,
    ACT_SET_CURSOR = 2'd1,
    ACT_READ_CELL  = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } reg_idx_e;

  // classified command handed from front to back
  typedef enum logic [3:0] {
    OP_CHAR   = 4'd0,
    OP_CR     = 4'd1,
    OP_LF     = 4'd2,
    OP_BS     = 4'd3,
    OP_TAB    = 4'd4,
    OP_SETCUR = 4'd5,
    OP_READ   = 4'd6,
    OP_REJECT = 4'd7,
    OP_CLEAR  = 4'd8
  } op_e;

  typedef struct packed {
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    logic [CHAR_W-1:0]  ch;
  } cell_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } colors_t;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [CHAR_W-1:0]    char_code;
    logic [POS_COL_W-1:0] pos_col;
    logic [POS_ROW_W-1:0] pos_row;
  } in_word_t;

  typedef struct packed {
    logic [POS_COL_W-1:0] cursor_col;
    logic [POS_ROW_W-1:0] cursor_row;
    logic [OFFSET_W-1:0]  cursor_offset;
    logic [CHAR_W-1:0]    cell_char;
    logic [COLOR_W-1:0]   cell_fg;
    logic [COLOR_W-1:0]   cell_bg;
    logic                 scrolled;
    logic                 rejected;
  } out_word_t;

  function automatic cell_t make_cell(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] fg,
                                      logic [COLOR_W-1:0] bg);
    cell_t c;
    c.ch = ch;
    c.fg = fg;
    c.bg = bg;
    return c;
  endfunction

  // one bit per column, set where a tab stops
  function automatic logic [COLS-1:0] tab_stop_mask();
    logic [COLS-1:0] m;
    m = '0;
    for (int i = 0; i < COLS; i++) begin
      m[i] = ((i % TAB_WIDTH) == 0);
    end
    return m;
  endfunction

  localparam logic [COLS-1:0] TAB_STOPS = tab_stop_mask();

endpackage

@@ hw/rtl/tcw_ram.sv @@
// generic single-port ram with registered read
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tcw_fifo.sv @@
// short command queue between the console front and back
module tcw_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output tcw_pkg::cmd_t pop_data_o,
  output logic          empty_o
);

  tcw_pkg::cmd_t             mem_q [tcw_pkg::Q_DEPTH];
  logic [tcw_pkg::Q_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [tcw_pkg::Q_AW:0]    cnt_q;
  logic                      do_push, do_pop;

  assign full_o     = (cnt_q == (tcw_pkg::Q_AW + 1)'(tcw_pkg::Q_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [tcw_pkg::Q_AW-1:0] ptr_inc(logic [tcw_pkg::Q_AW-1:0] p);
    logic [tcw_pkg::Q_AW-1:0] r;
    if (p == tcw_pkg::Q_AW'(tcw_pkg::Q_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + tcw_pkg::Q_AW'(1);
    end
    return r;
  endfunction

  // entries need no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (tcw_pkg::Q_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (tcw_pkg::Q_AW + 1)'(1);
      end
    end
  end

endmodule

@@ hw/rtl/tcw_front.sv @@
// front end: takes input words and classifies them into console commands
module tcw_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::in_word_t in_word_i,
  input  logic              init_busy_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output tcw_pkg::cmd_t     q_data_o
);

  logic in_range;

  // position check against the screen size
  assign in_range =
    ({1'b0, in_word_i.pos_col} < (tcw_pkg::POS_COL_W + 1)'(tcw_pkg::COLS)) &&
    ({1'b0, in_word_i.pos_row} < (tcw_pkg::POS_ROW_W + 1)'(tcw_pkg::ROWS));

  assign in_ready_o = !q_full_i && !init_busy_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  // decode action and control characters
  always_comb begin
    q_data_o.ch  = in_word_i.char_code;
    q_data_o.col = tcw_pkg::COL_W'(in_word_i.pos_col);
    q_data_o.row = tcw_pkg::ROW_W'(in_word_i.pos_row);
    q_data_o.op  = tcw_pkg::OP_CHAR;
    case (tcw_pkg::action_e'(in_word_i.action))
      tcw_pkg::ACT_PUT: begin
        case (in_word_i.char_code)
          tcw_pkg::CH_CR:  q_data_o.op = tcw_pkg::OP_CR;
          tcw_pkg::CH_LF:  q_data_o.op = tcw_pkg::OP_LF;
          tcw_pkg::CH_BS:  q_data_o.op = tcw_pkg::OP_BS;
          tcw_pkg::CH_TAB: q_data_o.op = tcw_pkg::OP_TAB;
          default:         q_data_o.op = tcw_pkg::OP_CHAR;
        endcase
      end
      tcw_pkg::ACT_SET_CURSOR: begin
        q_data_o.op = in_range ? tcw_pkg::OP_SETCUR : tcw_pkg::OP_REJECT;
      end
      tcw_pkg::ACT_READ_CELL: begin
        q_data_o.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_REJECT;
      end
      tcw_pkg::ACT_CLEAR: begin
        q_data_o.op = tcw_pkg::OP_CLEAR;
      end
      default: begin
        q_data_o.op = tcw_pkg::OP_CHAR;
      end
    endcase
  end

endmodule

@@ hw/rtl/tcw_back.sv @@
// back end: cursor, scrolling and the cell store, one command at a time
module tcw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcw_pkg::colors_t   colors_i,
  input  logic               q_empty_i,
  input  tcw_pkg::cmd_t      q_data_i,
  output logic               q_pop_o,
  output logic               init_busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcw_pkg::out_word_t out_word_o
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_BSWR,
    S_RDWAIT,
    S_SCROLL,
    S_DONE
  } state_e;

  state_e                      state_q;
  tcw_pkg::cmd_t               cmd_q;
  logic [tcw_pkg::COL_W-1:0]   cur_col_q, fill_col_q, col_inc;
  logic [tcw_pkg::ROW_W-1:0]   cur_row_q, top_q;
  logic [tcw_pkg::ADDR_W-1:0]  sweep_q;
  logic                        init_q, scrolled_q, rej_q, out_vld_q;
  tcw_pkg::cell_t              cell_q;
  tcw_pkg::out_word_t          out_q;

  logic [tcw_pkg::ROW_W-1:0]   row_sel, phys_sel;
  logic [tcw_pkg::COL_W-1:0]   col_sel;
  logic [tcw_pkg::ROW_W:0]     row_sum;
  logic                        ram_en, ram_we;
  logic [tcw_pkg::ADDR_W-1:0]  ram_addr;
  tcw_pkg::cell_t              ram_wdata;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;
  logic [tcw_pkg::OFF_CALC_W-1:0] offset_full;
  tcw_pkg::cell_t              blank_cell;

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign init_busy_o = init_q;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;
  assign col_inc     = cur_col_q + tcw_pkg::COL_W'(1);
  assign blank_cell  = tcw_pkg::make_cell(tcw_pkg::CH_SPACE, colors_i.fg, colors_i.bg);

  // screen row to ring row, then linear cell address
  always_comb begin
    row_sel = cur_row_q;
    col_sel = cur_col_q;
    if (cmd_q.op == tcw_pkg::OP_READ) begin
      row_sel = cmd_q.row;
      col_sel = cmd_q.col;
    end
    row_sum = {1'b0, top_q} + {1'b0, row_sel};
    if (row_sum >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS)) begin
      row_sum = row_sum - (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS);
    end
    phys_sel = row_sum[tcw_pkg::ROW_W-1:0];
    if (state_q == S_SCROLL) begin
      phys_sel = top_q;
      col_sel  = fill_col_q;
    end
    ram_addr = tcw_pkg::ADDR_W'(phys_sel) * tcw_pkg::ADDR_W'(tcw_pkg::COLS)
             + tcw_pkg::ADDR_W'(col_sel);
    if (state_q == S_SWEEP) begin
      ram_addr = sweep_q;
    end
  end

  // memory port control
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = blank_cell;
    case (state_q)
      S_SWEEP: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::make_cell(tcw_pkg::CH_SPACE, tcw_pkg::COLOR_GREY,
                                       tcw_pkg::COLOR_BLACK);
      end
      S_SCROLL, S_BSWR: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      S_EXEC: begin
        case (cmd_q.op)
          tcw_pkg::OP_CHAR: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = tcw_pkg::make_cell(cmd_q.ch, colors_i.fg, colors_i.bg);
          end
          tcw_pkg::OP_TAB: begin
            ram_en = 1'b1;
            ram_we = 1'b1;
          end
          tcw_pkg::OP_READ: begin
            ram_en = 1'b1;
          end
          default: begin
            ram_en = 1'b0;
          end
        endcase
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // linear cursor offset for the result word
  assign offset_full = tcw_pkg::OFF_CALC_W'(cur_row_q) * tcw_pkg::OFF_CALC_W'(tcw_pkg::COLS)
                     + tcw_pkg::OFF_CALC_W'(cur_col_q);

  // sequencer, cursor state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_SWEEP;
      init_q     <= 1'b1;
      sweep_q    <= '0;
      cmd_q      <= '0;
      cur_col_q  <= '0;
      cur_row_q  <= tcw_pkg::ROW_RESET;
      top_q      <= '0;
      fill_col_q <= '0;
      scrolled_q <= 1'b0;
      rej_q      <= 1'b0;
      cell_q     <= '0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      if (out_vld_q && out_ready_i && (state_q != S_DONE)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        // blank every cell in grey on black
        S_SWEEP: begin
          if (sweep_q == tcw_pkg::CELL_LAST) begin
            sweep_q <= '0;
            if (init_q) begin
              init_q  <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            sweep_q <= sweep_q + tcw_pkg::ADDR_W'(1);
          end
        end
        // fetch next command
        S_IDLE: begin
          if (!q_empty_i) begin
            cmd_q      <= q_data_i;
            scrolled_q <= 1'b0;
            rej_q      <= 1'b0;
            cell_q     <= '0;
            state_q    <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_q.op)
            // cell written this cycle, then advance with wrap
            tcw_pkg::OP_CHAR, tcw_pkg::OP_TAB: begin
              if (cur_col_q == tcw_pkg::COL_LAST) begin
                cur_col_q <= '0;
                if (cur_row_q == tcw_pkg::ROW_LAST) begin
                  fill_col_q <= '0;
                  state_q    <= S_SCROLL;
                end else begin
                  cur_row_q <= cur_row_q + tcw_pkg::ROW_W'(1);
                  state_q   <= S_DONE;
                end
              end else begin
                cur_col_q <= col_inc;
                if (cmd_q.op == tcw_pkg::OP_TAB && !tcw_pkg::TAB_STOPS[col_inc]) begin
                  state_q <= S_EXEC;
                end else begin
                  state_q <= S_DONE;
                end
              end
            end
            tcw_pkg::OP_CR: begin
              cur_col_q <= '0;
              state_q   <= S_DONE;
            end
            tcw_pkg::OP_LF: begin
              cur_col_q <= '0;
              if (cur_row_q == tcw_pkg::ROW_LAST) begin
                fill_col_q <= '0;
                state_q    <= S_SCROLL;
              end else begin
                cur_row_q <= cur_row_q + tcw_pkg::ROW_W'(1);
                state_q   <= S_DONE;
              end
            end
            // step back, at the origin stay put
            tcw_pkg::OP_BS: begin
              if (cur_col_q != '0) begin
                cur_col_q <= cur_col_q - tcw_pkg::COL_W'(1);
              end else if (cur_row_q != '0) begin
                cur_row_q <= cur_row_q - tcw_pkg::ROW_W'(1);
                cur_col_q <= tcw_pkg::COL_LAST;
              end
              state_q <= S_BSWR;
            end
            tcw_pkg::OP_SETCUR: begin
              cur_col_q <= cmd_q.col;
              cur_row_q <= cmd_q.row;
              state_q   <= S_DONE;
            end
            tcw_pkg::OP_READ: begin
              state_q <= S_RDWAIT;
            end
            tcw_pkg::OP_REJECT: begin
              rej_q   <= 1'b1;
              state_q <= S_DONE;
            end
            tcw_pkg::OP_CLEAR: begin
              cur_col_q <= '0;
              cur_row_q <= '0;
              top_q     <= '0;
              sweep_q   <= '0;
              state_q   <= S_SWEEP;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        // blank written at the new cursor
        S_BSWR: begin
          state_q <= S_DONE;
        end
        S_RDWAIT: begin
          cell_q  <= tcw_pkg::cell_t'(ram_rdata);
          state_q <= S_DONE;
        end
        // blank the old top row, then it becomes the bottom row
        S_SCROLL: begin
          if (fill_col_q == tcw_pkg::COL_LAST) begin
            top_q      <= (top_q == tcw_pkg::ROW_LAST) ? '0 : top_q + tcw_pkg::ROW_W'(1);
            scrolled_q <= 1'b1;
            state_q    <= S_DONE;
          end else begin
            fill_col_q <= fill_col_q + tcw_pkg::COL_W'(1);
          end
        end
        // hand the result word over once the output register is free
        S_DONE: begin
          if (!out_vld_q || out_ready_i) begin
            out_vld_q              <= 1'b1;
            out_q.cursor_col       <= tcw_pkg::POS_COL_W'(cur_col_q);
            out_q.cursor_row       <= tcw_pkg::POS_ROW_W'(cur_row_q);
            out_q.cursor_offset    <= offset_full[tcw_pkg::OFFSET_W-1:0];
            out_q.cell_char        <= cell_q.ch;
            out_q.cell_fg          <= cell_q.fg;
            out_q.cell_bg          <= cell_q.bg;
            out_q.scrolled         <= scrolled_q;
            out_q.rejected         <= rej_q;
            state_q                <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/text_console_writer.sv @@
// top level of the text console writer
// Text console of 80 columns by 25 rows with a cursor. Each word accepted on the input
// channel gives exactly one result word with the cursor after the action and its linear
// offset (row * 80 + column). A put character, carriage return, line feed or set cursor
// passes through the queue, the fetch, the execute step and the result register; a read
// cell also waits for the read data and a backspace also writes a blank. A tab writes
// one space per cycle until the next tab stop or the end of the row. Writes go through a
// single-port cell store that takes one write per cycle: a scroll blanks one row, a clear
// blanks all 2000 cells. After reset the same blanking pass runs and in_ready_o stays low
// until it is over; color writes on the configuration port are taken at any time. Up to
// two words wait in the command queue while the back end works, and a finished result
// waits in the output register while the back end goes on until its next result is due.
module text_console_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tcw_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tcw_pkg::out_word_t                out_word_o,
  input  logic                              cfg_we_i,
  input  logic [tcw_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcw_pkg::COLOR_W-1:0]       cfg_data_i
);

  logic [tcw_pkg::COLOR_W-1:0] fg_q, bg_q;
  tcw_pkg::colors_t            colors;
  logic                        init_busy, q_full, q_empty, q_push, q_pop;
  tcw_pkg::cmd_t               q_in, q_out;

  // color registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcw_pkg::FG_RESET;
      bg_q <= tcw_pkg::BG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcw_pkg::REG_FG: fg_q <= cfg_data_i;
        tcw_pkg::REG_BG: bg_q <= cfg_data_i;
        default: begin
          fg_q <= fg_q;
        end
      endcase
    end
  end

  assign colors.fg = fg_q;
  assign colors.bg = bg_q;

  tcw_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .init_busy_i (init_busy),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_in)
  );

  tcw_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_out),
    .empty_o     (q_empty)
  );

  tcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .colors_i    (colors),
    .q_empty_i   (q_empty),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ hw/rtl/tcw_chk.sv @@
// port checker for the text console writer and its bind
`include "text_console_writer_macros.svh"

module tcw_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tcw_pkg::out_word_t out_word_o
);

  logic stalled, cursor_ok, offset_ok, reject_ok;

  assign stalled   = out_valid_o && !out_ready_i;
  assign cursor_ok = (32'(out_word_o.cursor_col) < tcw_pkg::COLS) &&
                     (32'(out_word_o.cursor_row) < tcw_pkg::ROWS);
  assign offset_ok = out_word_o.cursor_offset ==
                     11'(32'(out_word_o.cursor_row) * tcw_pkg::COLS +
                         32'(out_word_o.cursor_col));
  assign reject_ok = (out_word_o.cell_char == 8'd0) && (out_word_o.cell_fg == 4'd0) &&
                     (out_word_o.cell_bg == 4'd0) && !out_word_o.scrolled;

  // a stalled result word holds
  `TCW_ASSERT_NEXT(a_out_hold, stalled, out_valid_o && $stable(out_word_o), "stalled result changed")

  // cursor stays on the screen
  `TCW_ASSERT_IMPL(a_cursor_range, out_valid_o, cursor_ok, "cursor off screen")

  // offset matches row and column
  `TCW_ASSERT_IMPL(a_offset, out_valid_o, offset_ok, "cursor offset mismatch")

  // a rejected action carries no cell and no scroll
  `TCW_ASSERT_IMPL(a_reject_clean, out_valid_o && out_word_o.rejected, reject_ok, "rejected word carries data")

endmodule

bind text_console_writer tcw_chk u_tcw_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
